// File: hw/rtl/rspe_pkg.sv
// Shared constants, types and the arctangent table of the shell profile evaluator.
package rspe_pkg;

	localparam int TH_W   = 31;
	localparam int X_W    = 32;
	localparam int OUT_W  = 48;
	localparam int CW     = 34;
	localparam int ROOT_W = 30;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 4;

	localparam logic [TH_W-1:0] PI_Q29      = 31'd1686629713;
	localparam logic [TH_W-1:0] HALF_PI_Q29 = 31'd843314856;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef enum logic [1:0] {
		REG_INNER   = 2'd0,
		REG_SHELL   = 2'd1,
		REG_OUTSIDE = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		CFG_MODE  = 2'd0,
		CFG_INNER = 2'd1,
		CFG_OUTER = 2'd2,
		CFG_NORM  = 2'd3
	} cfg_idx_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic signed [CW-1:0] atan_entry(input int i);
		logic signed [CW-1:0] r;
		r = '0;
		if (i <= 10) begin
			unique case (i)
				0: r = 34'sd843314856;
				1: r = 34'sd497837829;
				2: r = 34'sd263043836;
				3: r = 34'sd133525158;
				4: r = 34'sd67021686;
				5: r = 34'sd33543515;
				6: r = 34'sd16775850;
				7: r = 34'sd8388437;
				8: r = 34'sd4194282;
				9: r = 34'sd2097149;
				default: r = 34'sd1048575;
			endcase
		end else if (i <= 30) begin
			r = CW'((64'd1 << (30 - i)) - 64'd1);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/rspe_ifs.sv
// Request channel interfaces for the shell profile evaluator.
interface rspe_in_if;
	logic        valid;
	logic        ready;
	logic [30:0] theta;
	modport source(output valid, output theta, input ready);
	modport sink(input valid, input theta, output ready);
endinterface

interface rspe_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] brightness;
	logic [1:0]  region;
	logic        saturated;
	modport source(output valid, output brightness, output region, output saturated, input ready);
	modport sink(input valid, input brightness, input region, input saturated, output ready);
endinterface

// File: hw/rtl/radial_shell_profile_eval_top.sv
// Shell brightness profile evaluator: fold, CORDIC sine, square roots, scaling.
// Throughput: one request per cycle unless the output stalls; the CORDIC and
// the two 30-stage square root pipelines each retire one stage per cycle, and
// the whole pipe stalls as one.
// Reset: arst_n clears all valid bits and sets the registers to mode 1, zeros.
module radial_shell_profile_eval_top #(
	parameter int SINE_STAGES = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	rspe_in_if.sink     in_ch,
	rspe_out_if.source  out_ch
);
	import rspe_pkg::*;

	localparam int LAT = SINE_STAGES + ROOT_W + 6;

	logic              mode_q;
	logic [X_W-1:0]    inner_q;
	logic [X_W-1:0]    outer_q;
	logic [OUT_W-1:0]  norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			inner_q <= '0;
			outer_q <= '0;
			norm_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:  mode_q  <= cfg_data[0];
				CFG_INNER: inner_q <= cfg_data[X_W-1:0];
				CFG_OUTER: outer_q <= cfg_data[X_W-1:0];
				CFG_NORM:  norm_q  <= cfg_data;
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	// global advance
	logic en;
	logic vld [1:LAT];
	assign en          = !vld[LAT] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld[k] <= 1'b0;
		end else if (en) begin
			vld[1] <= in_ch.valid;
			for (int k = 2; k <= LAT; k++) vld[k] <= vld[k-1];
		end
	end

	// s1: fold into [0, pi/2], small-angle square
	logic [TH_W-1:0]   th_a, th_f;
	logic [TH_W-1:0]   fold_s1;
	logic [2*TH_W-1:0] prod_s1;

	always_comb begin
		th_a = (in_ch.theta >= PI_Q29) ? in_ch.theta - PI_Q29 : in_ch.theta;
		th_f = (th_a > HALF_PI_Q29) ? PI_Q29 - th_a : th_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= th_f;
			prod_s1 <= in_ch.theta * in_ch.theta;
		end
	end

	// CORDIC rotation, one stage per register
	logic signed [CW-1:0] cx_s [1:SINE_STAGES];
	logic signed [CW-1:0] cy_s [1:SINE_STAGES];
	logic signed [CW-1:0] cz_s [1:SINE_STAGES];
	logic [X_W-1:0]       xsa_s [1:SINE_STAGES];

	for (genvar i = 0; i < SINE_STAGES; i++) begin : g_cordic
		logic signed [CW-1:0] cx_in, cy_in, cz_in;
		logic [X_W-1:0]       xsa_in;
		if (i == 0) begin : g_first
			logic [2*TH_W:0] rnd;
			assign rnd    = {1'b0, prod_s1} + (63'd1 << 29);
			assign cx_in  = GAIN_Q30;
			assign cy_in  = '0;
			assign cz_in  = CW'({fold_s1, 1'b0});
			assign xsa_in = rnd[30 +: X_W];
		end else begin : g_next
			assign cx_in  = cx_s[i];
			assign cy_in  = cy_s[i];
			assign cz_in  = cz_s[i];
			assign xsa_in = xsa_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				xsa_s[i+1] <= xsa_in;
				if (!cz_in[CW-1]) begin
					cx_s[i+1] <= cx_in - (cy_in >>> i);
					cy_s[i+1] <= cy_in + (cx_in >>> i);
					cz_s[i+1] <= cz_in - atan_entry(i);
				end else begin
					cx_s[i+1] <= cx_in + (cy_in >>> i);
					cy_s[i+1] <= cy_in - (cx_in >>> i);
					cz_s[i+1] <= cz_in + atan_entry(i);
				end
			end
		end
	end

	// s2: clamp sine, square it
	logic [TH_W-1:0]   sclamp;
	logic [2*TH_W-1:0] sq_s2;
	logic [X_W-1:0]    xsa_s2;

	always_comb begin
		if (cy_s[SINE_STAGES][CW-1]) sclamp = '0;
		else if (cy_s[SINE_STAGES] > (34'sd1 <<< 30)) sclamp = TH_W'(1) << 30;
		else sclamp = cy_s[SINE_STAGES][TH_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2  <= sclamp * sclamp;
			xsa_s2 <= xsa_s[SINE_STAGES];
		end
	end

	// s3: select x, form differences and compare against thresholds
	logic [2*TH_W:0] sq_rnd;
	logic [X_W-1:0]  x_sel;
	logic [X_W-1:0]  dout_s3, din_s3;
	logic [1:0]      flg_s3;

	assign sq_rnd = {1'b0, sq_s2} + (63'd1 << 31);
	assign x_sel  = mode_q ? xsa_s2 : X_W'(sq_rnd[2*TH_W:32]);

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s3 <= outer_q - x_sel;
			din_s3  <= inner_q - x_sel;
			flg_s3  <= {x_sel < outer_q, x_sel < inner_q};
		end
	end

	logic [ROOT_W-1:0] r_out, r_in;

	rspe_isqrt u_sqrt_out (.clk(clk), .en(en), .d(dout_s3), .root(r_out));
	rspe_isqrt u_sqrt_in  (.clk(clk), .en(en), .d(din_s3),  .root(r_in));

	logic [1:0] flg_q [1:ROOT_W];
	always_ff @(posedge clk) begin
		if (en) begin
			flg_q[1] <= flg_s3;
			for (int k = 2; k <= ROOT_W; k++) flg_q[k] <= flg_q[k-1];
		end
	end

	// s4: profile value
	logic [ROOT_W-1:0] v_s4;
	region_t           region_s4;
	logic              clamp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s4 <= 1'b0;
			priority if (!flg_q[ROOT_W][1]) begin
				v_s4      <= '0;
				region_s4 <= REG_OUTSIDE;
			end else if (flg_q[ROOT_W][0]) begin
				region_s4 <= REG_INNER;
				if (r_in > r_out) begin
					v_s4     <= '0;
					clamp_s4 <= 1'b1;
				end else begin
					v_s4 <= r_out - r_in;
				end
			end else begin
				v_s4      <= r_out;
				region_s4 <= REG_SHELL;
			end
		end
	end

	// s5: split product
	logic [53:0] hi_s5;
	logic [54:0] lo_s5;
	region_t     region_s5;
	logic        clamp_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s5     <= norm_q[47:24] * v_s4;
			lo_s5     <= 55'(norm_q[23:0]) * 55'(v_s4) + (55'd1 << 27);
			region_s5 <= region_s4;
			clamp_s5  <= clamp_s4;
		end
	end

	// s6: combine, saturate
	logic [55:0] low_sum;
	logic [55:0] res;
	logic [OUT_W-1:0] bright_s6;
	region_t          region_s6;
	logic             sat_s6;

	assign low_sum = {28'd0, hi_s5[3:0], 24'd0} + 56'(lo_s5);
	assign res     = 56'(hi_s5[53:4]) + (low_sum >> 28);

	always_ff @(posedge clk) begin
		if (en) begin
			region_s6 <= region_s5;
			if (res > 56'(OUT_MAX)) begin
				bright_s6 <= OUT_MAX;
				sat_s6    <= 1'b1;
			end else begin
				bright_s6 <= res[OUT_W-1:0];
				sat_s6    <= clamp_s5;
			end
		end
	end

	assign out_ch.valid      = vld[LAT];
	assign out_ch.brightness = bright_s6;
	assign out_ch.region     = region_s6;
	assign out_ch.saturated  = sat_s6;

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.region == REG_OUTSIDE |-> out_ch.brightness == '0
		&& !out_ch.saturated) else $error("outside result not zero");

	a_sat_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.saturated |-> out_ch.brightness == OUT_MAX
		|| (out_ch.region == REG_INNER && out_ch.brightness == '0))
		else $error("bad saturated result");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld[1]) else $error("request lost at entry");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[1]) && $stable(v_s4)) else $error("pipe moved in stall");
endmodule

// File: hw/rtl/rspe_isqrt.sv
// Pipelined floor square root of a Q4.28 difference, one root bit per stage.
module rspe_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rspe_pkg::X_W-1:0]   d,
	output logic [rspe_pkg::ROOT_W-1:0] root
);
	import rspe_pkg::*;

	logic [RAD_W-1:0]  rad_s  [1:ROOT_W];
	logic [REM_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  remx;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_in  = {d, {(RAD_W - X_W){1'b0}}};
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		assign remx  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = remx >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_in << 2;
				rem_s[k+1]  <= ge ? remx - trial : remx;
				root_s[k+1] <= {root_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[ROOT_W];
endmodule
